// ===== src/ascii_can_frame_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
`ifndef ASCII_CAN_FRAME_PARSER_TOP_DEFINES_SVH
`define ASCII_CAN_FRAME_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// Types and constants shared by the ASCII CAN frame parser modules.
// ----------------------------------------------------------------------------
package acfp_pkg;

	localparam int MAX_DATA_BYTES = 8;

	localparam logic [31:0] ID_MAX   = 32'h0000_07ff;
	localparam logic [31:0] BYTE_MAX = 32'h0000_00ff;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ZERO = 3'd1,
		PH_DEC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_BIN  = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ID_BIG   = 3'd1,
		ST_TOO_MANY = 3'd2,
		ST_BYTE_BIG = 3'd3,
		ST_NO_ID    = 3'd4
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] acc;
		logic        have_id;
		logic [10:0] id;
		logic [3:0]  bytes;
		logic [63:0] payload;
	} state_t;

	typedef struct packed {
		logic        fire;
		status_t     status;
		logic [10:0] frame_id;
		logic [3:0]  byte_count;
		logic [63:0] payload;
	} result_t;

	localparam state_t LINE_CLEAR = '{
		phase:   PH_IDLE,
		acc:     32'd0,
		have_id: 1'b0,
		id:      11'd0,
		bytes:   4'd0,
		payload: 64'd0
	};

endpackage

// ===== src/acfp_step.sv =====
// ----------------------------------------------------------------------------
// acfp_step
// Next-state and result logic for one character of the frame parser.
// ----------------------------------------------------------------------------
module acfp_step (
	input  logic [7:0]       ch,
	input  acfp_pkg::state_t cur,
	output acfp_pkg::state_t nxt,
	output acfp_pkg::result_t res
);
	import acfp_pkg::*;

	logic       is_dec;
	logic       is_hex;
	logic       is_bin;
	logic [3:0] hex_val;

	assign is_dec = (ch >= "0") && (ch <= "9");
	assign is_bin = (ch == "0") || (ch == "1");
	assign is_hex = is_dec || ((ch >= "A") && (ch <= "F")) || ((ch >= "a") && (ch <= "f"));
	// Letters carry their value minus nine in the low nibble.
	assign hex_val = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

	always_comb begin
		phase_t  eff_phase;
		logic    cont;
		logic    ended;
		status_t err;

		nxt            = cur;
		res.fire       = 1'b0;
		res.status     = ST_OK;
		res.frame_id   = 11'd0;
		res.byte_count = 4'd0;
		res.payload    = 64'd0;
		eff_phase      = cur.phase;
		cont           = 1'b0;
		ended          = 1'b0;
		err            = ST_OK;

		if (cur.phase == PH_DONE) begin
			if (ch == 8'd0) begin
				nxt = LINE_CLEAR;
			end
		end else begin
			cont = 1'b1;
			// A leading zero may open a hex or binary prefix.
			if (cur.phase == PH_ZERO) begin
				if ((ch == "x") || (ch == "X")) begin
					nxt.phase = PH_HEX;
					nxt.acc   = 32'd0;
					cont      = 1'b0;
				end else if ((ch == "b") || (ch == "B")) begin
					nxt.phase = PH_BIN;
					nxt.acc   = 32'd0;
					cont      = 1'b0;
				end else begin
					eff_phase = PH_DEC;
					nxt.phase = PH_DEC;
				end
			end

			if (cont) begin
				case (eff_phase)
					PH_DEC: begin
						if (is_dec) begin
							nxt.acc = (cur.acc << 3) + (cur.acc << 1) + {28'd0, ch[3:0]};
							cont    = 1'b0;
						end else begin
							ended = 1'b1;
						end
					end
					PH_HEX: begin
						if (is_hex) begin
							nxt.acc = {cur.acc[27:0], hex_val};
							cont    = 1'b0;
						end else begin
							ended = 1'b1;
						end
					end
					PH_BIN: begin
						if (is_bin) begin
							nxt.acc = {cur.acc[30:0], ch[0]};
							cont    = 1'b0;
						end else begin
							ended = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end

			// The character that ends a number is still examined as a token start.
			if (ended) begin
				if (!cur.have_id) begin
					if (cur.acc > ID_MAX) begin
						err = ST_ID_BIG;
					end else begin
						nxt.id      = cur.acc[10:0];
						nxt.have_id = 1'b1;
					end
				end else if (cur.bytes >= 4'(MAX_DATA_BYTES)) begin
					err = ST_TOO_MANY;
				end else if (cur.acc > BYTE_MAX) begin
					err = ST_BYTE_BIG;
				end else begin
					nxt.payload = cur.payload |
						({56'd0, cur.acc[7:0]} << {cur.bytes[2:0], 3'b000});
					nxt.bytes   = cur.bytes + 4'd1;
				end

				if (err != ST_OK) begin
					res.fire   = 1'b1;
					res.status = err;
					cont       = 1'b0;
					if (ch == 8'd0) begin
						nxt = LINE_CLEAR;
					end else begin
						nxt.phase = PH_DONE;
					end
				end
			end

			if (cont) begin
				nxt.phase = PH_IDLE;
				if ((ch >= 8'd1) && (ch <= 8'd32)) begin
					nxt.phase = PH_IDLE;
				end else if (ch == "0") begin
					nxt.phase = PH_ZERO;
					nxt.acc   = 32'd0;
				end else if (is_dec) begin
					nxt.phase = PH_DEC;
					nxt.acc   = {28'd0, ch[3:0]};
				end else begin
					res.fire = 1'b1;
					if (nxt.have_id) begin
						res.status     = ST_OK;
						res.frame_id   = nxt.id;
						res.byte_count = nxt.bytes;
						res.payload    = nxt.payload;
					end else begin
						res.status = ST_NO_ID;
					end
					if (ch == 8'd0) begin
						nxt = LINE_CLEAR;
					end else begin
						nxt.phase = PH_DONE;
					end
				end
			end
		end
	end

endmodule

// ===== src/ascii_can_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_can_frame_parser_top: one character per cycle, set by the state update
// around acfp_step, unless a stalled result holds in_ready low; the result is
// registered in the cycle after the transfer of the character that ends the
// parse. arst_n clears the state and valid flag; payload registers are not reset.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [10:0] frame_id,
	output logic [3:0]  byte_count,
	output logic [63:0] payload
);
	import acfp_pkg::*;

	// The parse state is the only feedback path. Each accepted character is folded
	// into it, so a new character may follow every cycle while in_ready is high.
	state_t  state_q;
	state_t  state_nxt;
	result_t step_res;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [10:0] frame_id_q;
	logic [3:0]  byte_count_q;
	logic [63:0] payload_q;
	logic        in_xfer;

	acfp_step u_step (
		.ch  (ch),
		.cur (state_q),
		.nxt (state_nxt),
		.res (step_res)
	);

	// The input may move whenever the result register is empty or is being
	// drained in this same cycle, so a waiting result costs no bubble.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LINE_CLEAR;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && step_res.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload is loaded only with a new result; it holds while stalled.
	always_ff @(posedge clk) begin
		if (in_xfer && step_res.fire) begin
			status_q     <= step_res.status;
			frame_id_q   <= step_res.frame_id;
			byte_count_q <= step_res.byte_count;
			payload_q    <= step_res.payload;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_id   = frame_id_q;
	assign byte_count = byte_count_q;
	assign payload    = payload_q;

endmodule

// ===== src/acfp_checker.sv =====
// ----------------------------------------------------------------------------
// acfp_checker
// Port-level checks for the ASCII CAN frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_can_frame_parser_top_defines.svh"

module acfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [10:0] frame_id,
	input logic [3:0]  byte_count,
	input logic [63:0] payload
);
	import acfp_pkg::*;

	// A stalled result keeps its contents until its transfer.
	`ACFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(frame_id) && $stable(byte_count) && $stable(payload), "stalled result changed")

	// While a result waits, no character may be taken.
	`ACFP_ASSERT_NOW(a_stall_blocks_in, clk, arst_n, out_valid && !out_ready, !in_ready, "input accepted while result stalled")

	// Error results carry no frame contents.
	`ACFP_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && (status != ST_OK), (frame_id == 11'd0) && (byte_count == 4'd0) && (payload == 64'd0), "error result with nonzero fields")

	// Status codes and byte counts stay in range.
	`ACFP_ASSERT_NOW(a_ranges, clk, arst_n, out_valid, (status <= ST_NO_ID) && (byte_count <= 4'(MAX_DATA_BYTES)), "result field out of range")

endmodule

bind ascii_can_frame_parser_top acfp_checker u_acfp_checker (.*);

// ===== bench/acfp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// acfp_frame_checker
// Follows the character and frame channels of the ASCII CAN frame parser. It
// keeps its own copy of the parse state, works out the frame that each
// character closes, and compares every frame transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [10:0] frame_id,
	input  logic [3:0]  byte_count,
	input  logic [63:0] payload,
	output int          fail_count,
	output int          frames_waiting
);
	import acfp_pkg::*;

	localparam logic [7:0] CH_EOL       = 8'd0;
	localparam logic [7:0] CH_SPACE_MAX = 8'd32;

	typedef struct {
		status_t     code;
		logic [10:0] id;
		logic [3:0]  count;
		logic [63:0] data;
	} frame_rec_t;

	frame_rec_t  pending_frames[$];
	frame_rec_t  want;

	phase_t      line_phase;
	logic [31:0] num_acc;
	logic        id_seen;
	logic [10:0] frame_id_q;
	logic [3:0]  data_count;
	logic [63:0] data_bytes;

	task clear_line();
		line_phase = PH_IDLE;
		num_acc    = '0;
		id_seen    = 1'b0;
		frame_id_q = '0;
		data_count = '0;
		data_bytes = '0;
	endtask

	// Error frames carry only the status; all other fields read as zero.
	task post_frame(input status_t st);
		frame_rec_t f;
		f.code  = st;
		f.id    = (st == ST_OK) ? frame_id_q : 11'd0;
		f.count = (st == ST_OK) ? data_count : 4'd0;
		f.data  = (st == ST_OK) ? data_bytes : 64'd0;
		pending_frames.push_back(f);
	endtask

	// End of line starts over at once; anything else parks the line until it.
	task finish_line(input logic [7:0] c);
		if (c == CH_EOL)
			clear_line();
		else
			line_phase = PH_DONE;
	endtask

	task parse_char(input logic [7:0] c);
		logic       handled;
		logic       ended;
		logic [7:0] nib;
		status_t    st;
		handled = 1'b0;
		ended   = 1'b0;
		st      = ST_OK;
		if (line_phase == PH_DONE) begin
			if (c == CH_EOL)
				clear_line();
			handled = 1'b1;
		end else if (line_phase == PH_ZERO) begin
			if (c == "x" || c == "X") begin
				line_phase = PH_HEX;
				num_acc    = '0;
				handled    = 1'b1;
			end else if (c == "b" || c == "B") begin
				line_phase = PH_BIN;
				num_acc    = '0;
				handled    = 1'b1;
			end else begin
				line_phase = PH_DEC;
			end
		end
		if (!handled) begin
			case (line_phase)
			PH_DEC: begin
				if (c >= "0" && c <= "9") begin
					num_acc = num_acc * 32'd10 + {24'd0, c - "0"};
					handled = 1'b1;
				end else begin
					ended = 1'b1;
				end
			end
			PH_HEX: begin
				nib = 8'hff;
				if (c >= "0" && c <= "9")
					nib = c - "0";
				else if (c >= "A" && c <= "F")
					nib = c - "A" + 8'd10;
				else if (c >= "a" && c <= "f")
					nib = c - "a" + 8'd10;
				if (nib != 8'hff) begin
					num_acc = {num_acc[27:0], nib[3:0]};
					handled = 1'b1;
				end else begin
					ended = 1'b1;
				end
			end
			PH_BIN: begin
				if (c == "0" || c == "1") begin
					num_acc = {num_acc[30:0], c[0]};
					handled = 1'b1;
				end else begin
					ended = 1'b1;
				end
			end
			default: ;
			endcase
		end
		// The character that ends a number closes it first; the byte count
		// limit is tested ahead of the byte range.
		if (ended) begin
			if (!id_seen) begin
				if (num_acc > ID_MAX)
					st = ST_ID_BIG;
				else begin
					frame_id_q = num_acc[10:0];
					id_seen    = 1'b1;
				end
			end else if (data_count >= 4'(MAX_DATA_BYTES)) begin
				st = ST_TOO_MANY;
			end else if (num_acc > BYTE_MAX) begin
				st = ST_BYTE_BIG;
			end else begin
				data_bytes[data_count[2:0] * 8 +: 8] = num_acc[7:0];
				data_count = data_count + 4'd1;
			end
			if (st != ST_OK) begin
				post_frame(st);
				finish_line(c);
				handled = 1'b1;
			end
		end
		// Then the same character is taken as the start of the next token.
		if (!handled) begin
			line_phase = PH_IDLE;
			if (c == "0") begin
				line_phase = PH_ZERO;
				num_acc    = '0;
			end else if (c >= "1" && c <= "9") begin
				line_phase = PH_DEC;
				num_acc    = {24'd0, c - "0"};
			end else if (c == CH_EOL || c > CH_SPACE_MAX) begin
				post_frame(id_seen ? ST_OK : ST_NO_ID);
				finish_line(c);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			pending_frames.delete();
			fail_count     = 0;
			frames_waiting = 0;
		end else begin
			if (in_valid && in_ready)
				parse_char(ch);
			if (out_valid && out_ready) begin
				if (pending_frames.size() == 0) begin
					$error("frame transfer with none expected: status %0d id %0d",
						status, frame_id);
					fail_count++;
				end else begin
					want = pending_frames.pop_front();
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						fail_count++;
					end
					if (frame_id !== want.id) begin
						$error("frame_id: expected %0d, got %0d", want.id, frame_id);
						fail_count++;
					end
					if (byte_count !== want.count) begin
						$error("byte_count: expected %0d, got %0d", want.count,
							byte_count);
						fail_count++;
					end
					if (payload !== want.data) begin
						$error("payload: expected %h, got %h", want.data, payload);
						fail_count++;
					end
				end
			end
			frames_waiting = pending_frames.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Feeds text lines to the ASCII CAN frame parser one character per transfer
// and drains its frames with random stalls; acfp_frame_checker predicts and
// compares every frame, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import acfp_pkg::*;

	localparam int         CHAR_TARGET = 1200;
	localparam int         CYCLE_LIMIT = 300000;
	localparam logic [7:0] CH_EOL      = 8'd0;

	// Ways a number token can be spelled on the line.
	typedef enum int {NF_DEC, NF_HEX, NF_BIN, NF_LONG} number_form_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [10:0] frame_id;
	logic [3:0]  byte_count;
	logic [63:0] payload;

	int          fail_count;
	int          frames_waiting;
	int          cycle_count;
	int          chars_sent;
	int          frames_taken;
	logic        calm_in;
	logic        calm_out;

	// Characters of the line being built, sent in order.
	logic [7:0]  line_text[$];

	ascii_can_frame_parser_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.frame_id   (frame_id),
		.byte_count (byte_count),
		.payload    (payload)
	);

	acfp_frame_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ch             (ch),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.frame_id       (frame_id),
		.byte_count     (byte_count),
		.payload        (payload),
		.fail_count     (fail_count),
		.frames_waiting (frames_waiting)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run here as a failure.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic put(input logic [7:0] c);
		line_text.push_back(c);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	// One to three separators drawn from the whole space range 1..32.
	task automatic put_gap();
		repeat ($urandom_range(1, 3))
			put(8'($urandom_range(1, 32)));
	endtask

	// Spells v in the given form. Hex and binary get a random prefix case, and
	// a zero value sometimes gets no digits at all after its prefix. NF_LONG
	// ignores v and writes ten to fourteen decimal digits, which may wrap 32 bits.
	task automatic put_number(input logic [31:0] v, input number_form_t form);
		logic [7:0]  digs[$];
		logic [31:0] r;
		logic [3:0]  n;
		r = v;
		case (form)
		NF_DEC: begin
			do begin
				digs.push_front(8'("0" + r % 10));
				r = r / 10;
			end while (r != 0);
			if ($urandom_range(0, 5) == 0)
				put("0");
		end
		NF_HEX: begin
			put("0");
			put($urandom_range(0, 1) ? "x" : "X");
			while (r != 0) begin
				n = r[3:0];
				if (n < 4'd10)
					digs.push_front("0" + n);
				else
					digs.push_front(($urandom_range(0, 1) ? "a" : "A") + n - 8'd10);
				r = r >> 4;
			end
			if (v == 0 ? $urandom_range(0, 1) : ($urandom_range(0, 5) == 0))
				put("0");
		end
		NF_BIN: begin
			put("0");
			put($urandom_range(0, 1) ? "b" : "B");
			while (r != 0) begin
				digs.push_front("0" + r[0]);
				r = r >> 1;
			end
			if (v == 0 ? $urandom_range(0, 1) : ($urandom_range(0, 5) == 0))
				put("0");
		end
		default: begin
			put("0" + 8'($urandom_range(1, 9)));
			repeat ($urandom_range(9, 13))
				put("0" + 8'($urandom_range(0, 9)));
		end
		endcase
		foreach (digs[i])
			put(digs[i]);
	endtask

	function automatic number_form_t pick_form();
		int unsigned sel;
		sel = $urandom_range(0, 3);
		return (sel == 3) ? NF_BIN : ((sel == 2) ? NF_HEX : NF_DEC);
	endfunction

	// Most lines are well formed: an identifier and zero to nine data bytes,
	// a ninth byte being the overflow case. Values sit mostly in range with the
	// edges and the out-of-range values mixed in. A line ends at end of line or
	// at a stopping character followed by junk that the parser must ignore.
	// The rest are blank lines and raw noise over all 256 codes.
	task automatic build_line();
		int unsigned kind;
		int unsigned sel;
		int unsigned nbytes;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12))
				put(8'($urandom_range(0, 255)));
			put(CH_EOL);
		end else if (kind == 1) begin
			if ($urandom_range(0, 1))
				put_gap();
			put(CH_EOL);
		end else begin
			if ($urandom_range(0, 1))
				put_gap();
			sel = $urandom_range(0, 19);
			case (sel)
			0:       put_number(32'd0, pick_form());
			1:       put_number(32'd2047, pick_form());
			2:       put_number(32'd2048, pick_form());
			3:       put_number($urandom, pick_form());
			4:       put_number(32'd0, NF_LONG);
			default: put_number($urandom_range(0, 2047), pick_form());
			endcase
			nbytes = ($urandom_range(0, 7) == 0) ? 9 : $urandom_range(0, 8);
			repeat (nbytes) begin
				// Now and then two tokens touch, so the character that ends
				// one number starts the next.
				if ($urandom_range(0, 15) != 0)
					put_gap();
				sel = $urandom_range(0, 15);
				case (sel)
				0:       put_number(32'd0, pick_form());
				1:       put_number(32'd255, pick_form());
				2:       put_number(32'd256, pick_form());
				3:       put_number($urandom_range(256, 65535), pick_form());
				4:       put_number(32'd0, NF_LONG);
				default: put_number($urandom_range(0, 255), pick_form());
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1))
					put_gap();
				put(CH_EOL);
			end else begin
				put(8'($urandom_range(33, 255)));
				repeat ($urandom_range(0, 4))
					put(8'($urandom_range(1, 255)));
				put(CH_EOL);
			end
		end
	endtask

	// Called at a falling edge. Waits a random number of cycles, presents the
	// character and holds it until the transfer, then returns at the next
	// falling edge. With no gap, valid simply stays high for the next one.
	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		if (chars_sent % 150 == 0)
			calm_in = ($urandom_range(0, 2) == 0);
		gap = calm_in ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	// Stimulus: reset once, a handful of directed lines, then random lines
	// until the character budget is used up.
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		ch         = 8'd0;
		chars_sent = 0;
		calm_in    = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Largest identifier and byte, a bare hex prefix, an identifier one
		// over range, an empty line, and a binary number cut short by a digit
		// that starts a new token, followed by a stop and an ignored letter.
		put_str("2047 255");
		put(CH_EOL);
		put_str("0x");
		put(CH_EOL);
		put_str("2048");
		put(CH_EOL);
		put(CH_EOL);
		put_str("0b102!x");
		put(CH_EOL);
		while (line_text.size() != 0)
			send_char(line_text.pop_front());

		while (chars_sent < CHAR_TARGET) begin
			build_line();
			while (line_text.size() != 0)
				send_char(line_text.pop_front());
		end
		in_valid <= 1'b0;

		// Drain what is still owed, then keep the clock running in case the block
		// produces something nobody asked for.
		while (frames_waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Frame side: a random stall before each frame transfer, with calm
	// stretches where ready stays high throughout.
	initial begin
		int unsigned stall;
		out_ready    = 1'b0;
		frames_taken = 0;
		calm_out     = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (frames_taken % 20 == 0)
				calm_out = ($urandom_range(0, 2) == 0);
			stall = calm_out ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			frames_taken++;
			@(negedge clk);
		end
	end

endmodule

// ===== files.f =====
+incdir+src
src/acfp_pkg.sv
src/acfp_step.sv
src/ascii_can_frame_parser_top.sv
src/acfp_checker.sv
bench/acfp_frame_checker.sv
bench/tb_top.sv
